/* rtl/frt_pkg.sv */
// Package: shared types, constants and codes of the fragment reassembly tracker.
`default_nettype none
package frt_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_FRAGS_DEF = 64;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_TAKE  = 3'd1,
        OP_QUERY = 3'd2,
        OP_TICK  = 3'd3,
        OP_SWEEP = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IGNORED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_TOOLARGE = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] message_id;
        logic [63:0] source_hash;
        logic [15:0] fragment_index;
        logic [15:0] fragment_total;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic       complete;
        logic [3:0] slot;
        logic [6:0] received_total;
        logic [4:0] freed_count;
    } out_word_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SWEEP
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/frt_front.sv */
// Front end: two-entry input queue that holds accepted words for the back end.
`default_nettype none
module frt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  frt_pkg::in_word_t    in_word,
    output logic                 q_valid,
    input  wire logic            q_take,
    output frt_pkg::in_word_t    q_word
);
    import frt_pkg::*;

    in_word_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rd_ptr_reg];

    // store incoming words
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (q_take && q_valid)};
        end
    end
endmodule
`default_nettype wire

/* rtl/frt_back.sv */
// Back end: context table, match and update, slot sweep and result register.
`default_nettype none
module frt_back #(
    parameter int NUM_SLOTS = frt_pkg::NUM_SLOTS_DEF,
    parameter int MAX_FRAGS = frt_pkg::MAX_FRAGS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_take,
    input  frt_pkg::in_word_t    q_word,
    input  wire logic [31:0]     timeout_ticks,
    output logic                 empty,
    input  wire logic            pop,
    output frt_pkg::out_word_t   out_word
);
    import frt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [31:0] id_reg    [NUM_SLOTS];
    logic [63:0] hash_reg  [NUM_SLOTS];
    logic [6:0]  total_reg [NUM_SLOTS];
    logic [63:0] map_reg   [NUM_SLOTS];
    logic [6:0]  count_reg [NUM_SLOTS];
    logic [31:0] start_reg [NUM_SLOTS];
    logic [31:0] now_reg;

    back_state_t state_reg, state_next;
    in_word_t    cur_reg;
    logic [NUM_SLOTS-1:0] match_reg;
    logic [SW-1:0] sweep_reg;
    logic [4:0]    freed_reg;

    out_word_t res_reg;
    logic      res_full_reg;

    // match all slots in parallel
    logic [NUM_SLOTS-1:0] match_now;
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match_now[i] = valid_reg[i] && id_reg[i] == q_word.message_id
                           && hash_reg[i] == q_word.source_hash;
        end
    end

    // priority encode match and free slot
    logic          hit;
    logic [SW-1:0] hit_slot;
    logic          has_free;
    logic [SW-1:0] free_slot;
    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        has_free = 1'b0;
        free_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit = 1'b1;
                hit_slot = SW'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    // execute decision
    logic          tot_big;
    logic [6:0]    eff_total;
    logic [63:0]   eff_map;
    logic [6:0]    eff_count;
    logic [SW-1:0] tgt;
    logic          bit_set;
    logic          accept_frag;
    logic          do_open;
    logic          add_stop;
    logic [6:0]    new_count;
    always_comb
    begin
        tot_big  = cur_reg.fragment_total > 16'(MAX_FRAGS);
        do_open  = !hit && !tot_big && has_free;
        add_stop = !hit && (tot_big || !has_free);
        tgt      = hit ? hit_slot : free_slot;
        eff_total = hit ? total_reg[tgt] : cur_reg.fragment_total[6:0];
        eff_map   = hit ? map_reg[tgt] : 64'd0;
        eff_count = hit ? count_reg[tgt] : 7'd0;
        bit_set   = eff_map[cur_reg.fragment_index[5:0]];
        accept_frag = ({9'd0, eff_total} > cur_reg.fragment_index)
                      && (cur_reg.fragment_index < 16'd64) && !bit_set;
        new_count = eff_count + (accept_frag ? 7'd1 : 7'd0);
    end

    // sweep test on current slot
    logic expired;
    assign expired = valid_reg[sweep_reg] && ((now_reg - start_reg[sweep_reg]) > timeout_ticks);

    // result word for an execute cycle
    out_word_t exec_res;
    always_comb
    begin
        exec_res = '0;
        unique case (cur_reg.op) inside
            OP_ADD:
            begin
                if (add_stop)
                begin
                    exec_res.status = tot_big ? ST_TOOLARGE : ST_FULL;
                end
                else
                begin
                    exec_res.status = accept_frag ? ST_OK : ST_IGNORED;
                    exec_res.complete = (new_count == eff_total);
                    exec_res.slot = 4'(tgt);
                    exec_res.received_total = new_count;
                end
            end
            OP_TAKE, OP_QUERY:
            begin
                if (!hit)
                begin
                    exec_res.status = ST_NOTFOUND;
                end
                else
                begin
                    exec_res.complete = (count_reg[tgt] == total_reg[tgt]);
                    exec_res.status = exec_res.complete ? ST_OK : ST_NOTFOUND;
                    exec_res.slot = 4'(tgt);
                    exec_res.received_total = count_reg[tgt];
                end
            end
            OP_TICK:
            begin
                exec_res.status = ST_OK;
            end
            default:
            begin
                exec_res.status = ST_IGNORED;
            end
        endcase
    end

    assign q_take = (state_reg == BK_IDLE) && q_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_word.op == OP_SWEEP) ? BK_SWEEP : BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!res_full_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SWEEP:
            begin
                if (sweep_reg == SW'(NUM_SLOTS - 1) && !res_full_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // output strobes
    logic exec_fire, sweep_step, sweep_done;
    always_comb
    begin
        exec_fire  = 1'b0;
        sweep_step = 1'b0;
        sweep_done = 1'b0;
        unique case (state_reg)
            BK_EXEC:  exec_fire = !res_full_reg;
            BK_SWEEP:
            begin
                sweep_step = (sweep_reg != SW'(NUM_SLOTS - 1)) || !res_full_reg;
                sweep_done = (sweep_reg == SW'(NUM_SLOTS - 1)) && !res_full_reg;
            end
            default: ;
        endcase
    end

    // table payload updates
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            cur_reg   <= q_word;
            match_reg <= match_now;
        end
        if (exec_fire && cur_reg.op == OP_ADD && !add_stop)
        begin
            if (do_open)
            begin
                id_reg[tgt]    <= cur_reg.message_id;
                hash_reg[tgt]  <= cur_reg.source_hash;
                total_reg[tgt] <= cur_reg.fragment_total[6:0];
                start_reg[tgt] <= now_reg;
            end
            map_reg[tgt]   <= eff_map | (accept_frag ? (64'd1 << cur_reg.fragment_index[5:0]) : 64'd0);
            count_reg[tgt] <= new_count;
        end
    end

    // control state, valid bits, time and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            valid_reg    <= '0;
            now_reg      <= '0;
            sweep_reg    <= '0;
            freed_reg    <= '0;
            res_full_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && res_full_reg)
            begin
                res_full_reg <= 1'b0;
            end
            if (q_take)
            begin
                sweep_reg <= '0;
                freed_reg <= '0;
            end
            if (exec_fire)
            begin
                res_reg      <= exec_res;
                res_full_reg <= 1'b1;
                if (cur_reg.op == OP_ADD && do_open)
                begin
                    valid_reg[tgt] <= 1'b1;
                end
                if (cur_reg.op == OP_TAKE && hit && count_reg[tgt] == total_reg[tgt])
                begin
                    valid_reg[tgt] <= 1'b0;
                end
                if (cur_reg.op == OP_TICK)
                begin
                    now_reg <= now_reg + 32'd1;
                end
            end
            if (sweep_step)
            begin
                if (expired)
                begin
                    valid_reg[sweep_reg] <= 1'b0;
                end
                if (!sweep_done)
                begin
                    freed_reg <= freed_reg + (expired ? 5'd1 : 5'd0);
                    sweep_reg <= sweep_reg + SW'(1);
                end
            end
            if (sweep_done)
            begin
                res_reg      <= '{status: ST_OK, complete: 1'b0, slot: 4'd0,
                                  received_total: 7'd0,
                                  freed_count: freed_reg + (expired ? 5'd1 : 5'd0)};
                res_full_reg <= 1'b1;
            end
        end
    end

    assign empty    = !res_full_reg;
    assign out_word = res_reg;
endmodule
`default_nettype wire

/* rtl/fragment_reassembly_tracker.sv */
// Top level of the fragment reassembly tracker.
`default_nettype none
// Tracks up to NUM_SLOTS reassembly contexts keyed by message id and source hash.
// Input words enter a two-entry queue; the back end takes one word at a time.
// Add, take, query and tick match the key across all slots in parallel and then
// execute once the result register is free; a sweep steps one slot per cycle,
// waiting at the last for a free result register. A single result register holds
// each answer until popped. timeout_ticks is written through the cfg channel.
module fragment_reassembly_tracker #(
    parameter int NUM_SLOTS = frt_pkg::NUM_SLOTS_DEF,
    parameter int MAX_FRAGS = frt_pkg::MAX_FRAGS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  frt_pkg::in_word_t    in_word,
    output logic                 empty,
    input  wire logic            pop,
    output frt_pkg::out_word_t   out_word,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [31:0]     cfg_data
);
    import frt_pkg::*;

    logic        q_valid, q_take;
    in_word_t    q_word;
    logic [31:0] timeout_reg;

    assign cfg_ready = 1'b1;

    // hold the timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    frt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_word (in_word),
        .q_valid (q_valid),
        .q_take  (q_take),
        .q_word  (q_word)
    );

    frt_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_FRAGS (MAX_FRAGS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_take        (q_take),
        .q_word        (q_word),
        .timeout_ticks (timeout_reg),
        .empty         (empty),
        .pop           (pop),
        .out_word      (out_word)
    );
endmodule
`default_nettype wire
